>>> rtl/core/clx_pkg.sv
// ----------------------------------------------------------------------------
// clx_pkg: shared types and constants for the C subset lexer
// Token kinds, result record, position width and keyword patterns.
// ----------------------------------------------------------------------------
package clx_pkg;

    localparam int POS_BITS = 16;    // 8..32, position counter wraps at 2^POS_BITS
    localparam int FIFO_DEPTH = 4;   // result queue, room for two pushes per step
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [2:0] K_NUM     = 3'd0;
    localparam logic [2:0] K_IDENT   = 3'd1;
    localparam logic [2:0] K_KEYWORD = 3'd2;
    localparam logic [2:0] K_PUNCT   = 3'd3;
    localparam logic [2:0] K_END     = 3'd4;
    localparam logic [2:0] K_ERROR   = 3'd5;

    // first six bytes of an identifier, first byte lowest
    localparam logic [47:0] KW_RETURN = 48'h6E_72_75_74_65_72;
    localparam logic [47:0] KW_IF     = 48'h00_00_00_00_66_69;
    localparam logic [47:0] KW_ELSE   = 48'h00_00_65_73_6C_65;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start_pos;
        logic [15:0] tok_len;
        logic [63:0] num_value;
        logic        last;
    } t_tok;

    // requests pushed into the result queue by one step
    typedef struct packed {
        logic v0;   // first result present
        logic v1;   // second result present (only with v0)
    } t_push;

    function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] p);
        return 16'(p);
    endfunction

endpackage

>>> rtl/core/clx_byte_if.sv
// ----------------------------------------------------------------------------
// clx_byte_if: source byte channel
// Valid/ready channel carrying one text byte per request.
// ----------------------------------------------------------------------------
interface clx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

>>> rtl/core/clx_tok_if.sv
// ----------------------------------------------------------------------------
// clx_tok_if: token channel
// Valid/ready channel carrying one token record per request.
// ----------------------------------------------------------------------------
interface clx_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] tok_len;
    logic [63:0] num_value;
    logic        last;

    modport source (output valid, output kind, output start_pos, output tok_len,
                    output num_value, output last, input ready);
    modport sink   (input valid, input kind, input start_pos, input tok_len,
                    input num_value, input last, output ready);
endinterface

>>> rtl/core/clx_step.sv
// ----------------------------------------------------------------------------
// clx_step: input register and lexer step
// Holds one byte, classifies it against the running token state and
// produces up to two token records per byte.
// ----------------------------------------------------------------------------
module clx_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_ch,
    output logic          o_ready,
    input  logic          i_space2,
    output clx_pkg::t_push o_push,
    output clx_pkg::t_tok  o_res0,
    output clx_pkg::t_tok  o_res1
);
    import clx_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE  = 5'b00001,
        M_NUM   = 5'b00010,
        M_IDENT = 5'b00100,
        M_PEND  = 5'b01000,
        M_ERR   = 5'b10000
    } t_mode;

    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_EQ  = 8'd61;

    logic                r_v;
    logic [7:0]          r_ch;
    t_mode               r_mode, n_mode;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_start, n_start;
    logic [63:0]         r_acc, n_acc;
    logic [47:0]         r_prefix, n_prefix;
    logic [15:0]         r_len, n_len;

    logic        consume;
    logic        is_space, is_digit, is_alpha, is_punct, is_pair;
    logic [3:0]  digit;
    logic [67:0] acc_x10;
    logic [15:0] len_inc;
    logic        is_kw;
    logic        other;
    logic        fv, bv;
    t_tok        f, b;

    assign consume = r_v && i_space2;
    assign o_ready = !r_v || i_space2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= 1'b0;
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_acc    <= '0;
            r_prefix <= '0;
            r_len    <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_v <= 1'b1;
            end else if (consume) begin
                r_v <= 1'b0;
            end
            if (consume) begin
                r_mode   <= n_mode;
                r_pos    <= n_pos;
                r_start  <= n_start;
                r_acc    <= n_acc;
                r_prefix <= n_prefix;
                r_len    <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch <= i_ch;
        end
    end

    // byte classes
    always_comb begin
        is_space = (r_ch == 8'd32) || (r_ch >= 8'd9 && r_ch <= 8'd13);
        is_digit = (r_ch >= 8'd48 && r_ch <= 8'd57);
        is_alpha = (r_ch >= 8'd97 && r_ch <= 8'd122) || (r_ch >= 8'd65 && r_ch <= 8'd90)
                   || (r_ch == 8'd95);
        is_punct = (r_ch >= 8'd33 && r_ch <= 8'd47) || (r_ch >= 8'd58 && r_ch <= 8'd64)
                   || (r_ch >= 8'd91 && r_ch <= 8'd96) || (r_ch >= 8'd123 && r_ch <= 8'd126);
        is_pair  = (r_ch == CH_EQ) || (r_ch == 8'd33) || (r_ch == 8'd60) || (r_ch == 8'd62);
        digit    = 4'(r_ch - 8'd48);
        // acc * 10 + d; any carry into the top bits means saturation
        acc_x10  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 68'(digit);
        len_inc  = (r_len != 16'hFFFF) ? r_len + 16'd1 : r_len;
        is_kw    = (r_len == 16'd6 && r_prefix == KW_RETURN)
                || (r_len == 16'd2 && r_prefix == KW_IF)
                || (r_len == 16'd4 && r_prefix == KW_ELSE);
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos + 1'b1;
        n_start  = r_start;
        n_acc    = r_acc;
        n_prefix = r_prefix;
        n_len    = r_len;
        other    = 1'b0;
        fv       = 1'b0;
        bv       = 1'b0;
        f        = '0;
        b        = '0;

        case (r_mode)
            M_ERR: begin
                if (r_ch == CH_NUL) begin
                    bv          = 1'b1;
                    b.kind      = K_END;
                    b.start_pos = pos16(r_pos);
                end
            end
            M_NUM: begin
                if (is_digit) begin
                    n_acc = (|acc_x10[67:64]) ? {64{1'b1}} : acc_x10[63:0];
                    n_len = len_inc;
                end else begin
                    other = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alpha || is_digit) begin
                    if (r_len < 16'd6) begin
                        n_prefix = r_prefix | (48'(r_ch) << {r_len[2:0], 3'b000});
                    end
                    n_len = len_inc;
                end else begin
                    other = 1'b1;
                end
            end
            M_PEND: begin
                if (r_ch == CH_EQ) begin
                    fv          = 1'b1;
                    f.kind      = K_PUNCT;
                    f.start_pos = pos16(r_start);
                    f.tok_len   = 16'd2;
                    n_mode      = M_IDLE;
                    n_start     = '0;
                    n_acc       = '0;
                    n_prefix    = '0;
                    n_len       = '0;
                end else begin
                    other = 1'b1;
                end
            end
            default: begin
                other = 1'b1;
            end
        endcase

        if (other) begin
            // flush the open token
            case (r_mode)
                M_NUM: begin
                    fv          = 1'b1;
                    f.kind      = K_NUM;
                    f.start_pos = pos16(r_start);
                    f.tok_len   = r_len;
                    f.num_value = r_acc;
                end
                M_IDENT: begin
                    fv          = 1'b1;
                    f.kind      = is_kw ? K_KEYWORD : K_IDENT;
                    f.start_pos = pos16(r_start);
                    f.tok_len   = r_len;
                end
                M_PEND: begin
                    fv          = 1'b1;
                    f.kind      = K_PUNCT;
                    f.start_pos = pos16(r_start);
                    f.tok_len   = 16'd1;
                end
                default: begin
                end
            endcase
            n_mode   = M_IDLE;
            n_start  = '0;
            n_acc    = '0;
            n_prefix = '0;
            n_len    = '0;

            // open the next token with this byte
            if (r_ch == CH_NUL) begin
                bv          = 1'b1;
                b.kind      = K_END;
                b.start_pos = pos16(r_pos);
            end else if (is_space) begin
                n_mode = M_IDLE;
            end else if (is_digit) begin
                n_mode  = M_NUM;
                n_start = r_pos;
                n_acc   = 64'(digit);
                n_len   = 16'd1;
            end else if (is_alpha) begin
                n_mode   = M_IDENT;
                n_start  = r_pos;
                n_prefix = 48'(r_ch);
                n_len    = 16'd1;
            end else if (is_pair) begin
                n_mode  = M_PEND;
                n_start = r_pos;
            end else if (is_punct) begin
                bv          = 1'b1;
                b.kind      = K_PUNCT;
                b.start_pos = pos16(r_pos);
                b.tok_len   = 16'd1;
            end else begin
                bv          = 1'b1;
                b.kind      = K_ERROR;
                b.start_pos = pos16(r_pos);
                b.tok_len   = 16'd1;
                n_mode      = M_ERR;
            end
        end

        // end of text starts a fresh one
        if (r_ch == CH_NUL) begin
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_start  = '0;
            n_acc    = '0;
            n_prefix = '0;
            n_len    = '0;
        end
    end

    always_comb begin
        o_push.v0 = consume && (fv || bv);
        o_push.v1 = consume && fv && bv;
        o_res0      = fv ? f : b;
        o_res0.last = !(fv && bv);
        o_res1      = b;
        o_res1.last = 1'b1;
    end

endmodule

>>> rtl/core/clx_out_fifo.sv
// ----------------------------------------------------------------------------
// clx_out_fifo: token result queue
// Small register queue taking up to two records per cycle, giving one.
// ----------------------------------------------------------------------------
module clx_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clx_pkg::t_push i_push,
    input  clx_pkg::t_tok  i_res0,
    input  clx_pkg::t_tok  i_res1,
    output logic           o_space2,
    output logic           o_valid,
    input  logic           i_ready,
    output clx_pkg::t_tok  o_res
);
    import clx_pkg::*;

    t_tok               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, n_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt, n_cnt;
    logic [FIFO_AW-1:0] wp1;
    logic               pop;

    assign wp1      = r_wp + 1'b1;
    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_cnt != '0);
    assign o_space2 = (r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign o_res    = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_cnt = r_cnt;
        if (i_push.v0) begin
            n_wp  = n_wp + 1'b1;
            n_cnt = n_cnt + 1'b1;
        end
        if (i_push.v1) begin
            n_wp  = n_wp + 1'b1;
            n_cnt = n_cnt + 1'b1;
        end
        if (pop) begin
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_cnt <= n_cnt;
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push.v1) begin
            r_mem[wp1] <= i_res1;
        end
    end

endmodule

>>> rtl/core/c_subset_lexer_unit.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_unit: streaming lexer for a small C subset
// Turns a byte stream into number, identifier, keyword, punctuator, end
// and error tokens.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | role
//  ---------+-----+-------------------------------------------+------------------
//  i_byte   | in  | ch[7:0]                                   | one text byte
//  o_tok    | out | kind, start_pos, tok_len, num_value, last | one token record
//
//  A byte request is taken into the input register, the lexer step works on
//  it once the queue has room for two records and writes 0..2 token records
//  into a 4-entry queue. Throughput is one byte per cycle while the queue
//  keeps room for two records; a run of bytes giving two tokens each is
//  bounded by the one-record-per-cycle output port. Synchronous active-low
//  reset empties the queue and returns the lexer to idle at position 0.
//  Back-pressure on o_tok fills the queue, then holds i_byte.ready low.
// ----------------------------------------------------------------------------
module c_subset_lexer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clx_byte_if.sink   i_byte,
    clx_tok_if.source  o_tok
);
    import clx_pkg::*;

    t_push push;     // records produced by this step
    t_tok  res0;     // flushed token, or the byte's own token
    t_tok  res1;     // byte's own token after a flush
    t_tok  head;     // record at the queue head
    logic  space2;   // queue can take a full step's output

    // classification, running token state and the saturating x10 accumulator
    clx_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .i_ch    (i_byte.ch),
        .o_ready (i_byte.ready),
        .i_space2(space2),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    // result queue decouples token bursts from the consumer
    clx_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_space2(space2),
        .o_valid (o_tok.valid),
        .i_ready (o_tok.ready),
        .o_res   (head)
    );

    assign o_tok.kind      = head.kind;
    assign o_tok.start_pos = head.start_pos;
    assign o_tok.tok_len   = head.tok_len;
    assign o_tok.num_value = head.num_value;
    assign o_tok.last      = head.last;

endmodule

>>> bench/c_subset_lexer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_subset_lexer_unit_test: self-checking bench for the C subset lexer
// Feeds byte streams (directed texts, then random well-formed and broken
// texts) under random idling and long output stalls. A scoreboard predicts
// every token and checks it on arrival.
// ----------------------------------------------------------------------------
module c_subset_lexer_unit_test;
    import clx_pkg::*;

    localparam logic [7:0] TEXT_END = 8'h00;
    localparam int HOLD_CYCLES = 40;     // long output stall, fills the token queue
    localparam int MAX_SHOWN = 40;       // cap on printed mismatches

    typedef enum logic [2:0] {LX_IDLE, LX_NUM, LX_IDENT, LX_PEND, LX_ERR} t_lex_mode;

    // ------------------------------------------------------------------------
    // Token scoreboard: keeps its own lexer state, turns every accepted byte
    // into the tokens it should cause and checks arriving tokens in order.
    // ------------------------------------------------------------------------
    class t_token_scoreboard;
        t_lex_mode           lex_mode;
        logic [POS_BITS-1:0] lex_pos;
        logic [POS_BITS-1:0] tok_begin;
        logic [63:0]         num_acc;
        logic [47:0]         word_head;   // first six bytes, first byte lowest
        logic [15:0]         run_len;     // saturating token length
        t_tok                expected_tokens[$];
        t_tok                fresh[$];    // tokens of the byte being noted
        int                  failures;
        int                  shown;
        int                  checked;
        int                  saturated;
        int                  seen[8];

        function new();
            lex_mode = LX_IDLE;
            lex_pos  = '0;
            clear_token();
        endfunction

        function void clear_token();
            num_acc   = '0;
            word_head = '0;
            run_len   = '0;
            tok_begin = '0;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function bit is_punct(logic [7:0] c);
            return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                   (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
        endfunction

        function void add(logic [2:0] kind, logic [POS_BITS-1:0] at,
                          logic [15:0] len, logic [63:0] value);
            t_tok t;
            t.kind      = kind;
            t.start_pos = 16'(at);
            t.tok_len   = len;
            t.num_value = value;
            t.last      = 1'b0;
            fresh.push_back(t);
        endfunction

        // close the open token, if any
        function void flush();
            bit kw;
            kw = (run_len == 16'd6 && word_head == KW_RETURN) ||
                 (run_len == 16'd2 && word_head == KW_IF) ||
                 (run_len == 16'd4 && word_head == KW_ELSE);
            case (lex_mode)
                LX_NUM:   add(K_NUM, tok_begin, run_len, num_acc);
                LX_IDENT: add(kw ? K_KEYWORD : K_IDENT, tok_begin, run_len, '0);
                LX_PEND:  add(K_PUNCT, tok_begin, 16'd1, '0);
                default: ;
            endcase
            clear_token();
            lex_mode = LX_IDLE;
        endfunction

        // byte seen with nothing open
        function void open_token(logic [7:0] c, logic [POS_BITS-1:0] at);
            if (c == TEXT_END) begin
                add(K_END, at, 16'd0, '0);
            end else if (is_space(c)) begin
            end else if (is_digit(c)) begin
                lex_mode  = LX_NUM;
                tok_begin = at;
                num_acc   = 64'(c - "0");
                run_len   = 16'd1;
            end else if (is_alpha(c)) begin
                lex_mode  = LX_IDENT;
                tok_begin = at;
                word_head = 48'(c);
                run_len   = 16'd1;
            end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
                lex_mode  = LX_PEND;
                tok_begin = at;
            end else if (is_punct(c)) begin
                add(K_PUNCT, at, 16'd1, '0);
            end else begin
                add(K_ERROR, at, 16'd1, '0);
                lex_mode = LX_ERR;
            end
        endfunction

        function void note_byte(logic [7:0] c);
            logic [POS_BITS-1:0] at;
            logic [67:0]         wide;
            at = lex_pos;
            fresh.delete();
            if (lex_mode == LX_ERR) begin
                if (c == TEXT_END) add(K_END, at, 16'd0, '0);
            end else if (lex_mode == LX_NUM && is_digit(c)) begin
                // any carry past bit 63 pins the value at all ones
                wide = {4'b0, num_acc} * 68'd10 + {60'b0, c - "0"};
                num_acc = (wide[67:64] != 4'd0) ? '1 : wide[63:0];
                if (run_len != 16'hFFFF) run_len++;
            end else if (lex_mode == LX_IDENT && (is_alpha(c) || is_digit(c))) begin
                if (run_len < 16'd6) word_head[8*run_len +: 8] = c;
                if (run_len != 16'hFFFF) run_len++;
            end else if (lex_mode == LX_PEND && c == "=") begin
                add(K_PUNCT, tok_begin, 16'd2, '0);
                clear_token();
                lex_mode = LX_IDLE;
            end else begin
                flush();
                open_token(c, at);
            end

            if (c == TEXT_END) begin
                lex_mode = LX_IDLE;
                lex_pos  = '0;
                clear_token();
            end else begin
                lex_pos = at + 1'b1;
            end

            if (fresh.size() != 0) fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[i]) expected_tokens.push_back(fresh[i]);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                failures++;
                if (shown < MAX_SHOWN)
                    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
                shown++;
            end
        endfunction

        function void check_token(t_tok got);
            t_tok want;
            if (expected_tokens.size() == 0) begin
                failures++;
                if (shown < MAX_SHOWN)
                    $display("%0t ns: unexpected token, expected none, actual kind %0d at %0d",
                             $time, got.kind, got.start_pos);
                shown++;
                return;
            end
            want = expected_tokens.pop_front();
            compare("kind", want.kind, got.kind);
            compare("start_pos", want.start_pos, got.start_pos);
            compare("tok_len", want.tok_len, got.tok_len);
            compare("num_value", want.num_value, got.num_value);
            compare("last", want.last, got.last);
            checked++;
            if (got.kind <= K_ERROR) seen[got.kind]++;
            if (got.kind == K_NUM && got.num_value == '1) saturated++;
        endfunction

        function int outstanding();
            return expected_tokens.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    clx_byte_if byte_ch ();
    clx_tok_if  tok_ch ();

    c_subset_lexer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_tok   (tok_ch)
    );

    t_token_scoreboard tokens = new();

    bit src_calm  = 1'b0;   // sender offers a request every cycle
    bit snk_calm  = 1'b0;   // receiver is always ready
    bit hold_req  = 1'b0;   // asks the receiver for one long stall
    int bytes_sent;
    int texts_sent;

    // ------------------------------------------------------------------------
    // Byte sender. Inputs move on the falling edge; a request counts at the
    // rising edge where valid and ready are both high, and that byte then
    // goes to the scoreboard. Random gaps follow about 7 requests in 100
    // unless the sender is in its calm stretch.
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] c);
        @(negedge i_clk);
        byte_ch.valid <= 1'b1;
        byte_ch.ch    <= c;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) @(posedge i_clk);
        tokens.note_byte(c);
        bytes_sent++;
        if (c == TEXT_END) texts_sent++;
        if (!src_calm && $urandom_range(99) < 7) begin
            @(negedge i_clk);
            byte_ch.valid <= 1'b0;
            byte_ch.ch    <= 8'($urandom);
            repeat ($urandom_range(2)) @(negedge i_clk);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // byte pickers for the random texts
    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(3) == 0) ? 8'("0" + $urandom_range(9)) : rand_alpha();
    endfunction

    // any one-byte punctuator, the four that may pair with '=' among them
    function automatic logic [7:0] rand_punct();
        int r;
        r = $urandom_range(31);
        if (r < 15) return 8'(33 + r);
        if (r < 22) return 8'(58 + r - 15);
        if (r < 28) return 8'(91 + r - 22);
        return 8'(123 + r - 28);
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
    endfunction

    // control bytes, DEL, high bytes, or plain noise (never the end byte)
    function automatic logic [7:0] rand_bad();
        case ($urandom_range(4))
            0: return 8'($urandom_range(1, 8));
            1: return 8'($urandom_range(14, 31));
            2: return 8'd127;
            3: return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // One random text: a run of tokens, glued or spaced, closed by the end
    // byte. Mostly well formed; now and then a bad byte and noise break it, and
    // the lexer must skip the rest until the end byte.
    task automatic send_random_text();
        int    pieces;
        int    r;
        int    n;
        string word;
        pieces = $urandom_range(1, 12);
        repeat (pieces) begin
            r = $urandom_range(99);
            if (r < 22) begin
                // number, now and then long enough to saturate
                if ($urandom_range(9) == 0) begin
                    n = $urandom_range(18, 24);
                    send_byte(8'("1" + $urandom_range(8)));
                end else begin
                    n = $urandom_range(1, 4);
                    send_byte(8'("0" + $urandom_range(9)));
                end
                repeat (n - 1) send_byte(8'("0" + $urandom_range(9)));
            end else if (r < 50) begin
                if ($urandom_range(2) == 0) begin
                    // keyword, or a near miss: one byte short or one too many
                    case ($urandom_range(2))
                        0: word = "return";
                        1: word = "if";
                        default: word = "else";
                    endcase
                    n = $urandom_range(3);
                    if (n == 1) word = word.substr(0, word.len() - 2);
                    send_text(word);
                    if (n == 2) send_byte(rand_alnum());
                end else begin
                    send_byte(rand_alpha());
                    repeat ($urandom_range(9)) send_byte(rand_alnum());
                end
            end else if (r < 65) begin
                // operator that may take a second '='
                case ($urandom_range(3))
                    0: send_byte("=");
                    1: send_byte("!");
                    2: send_byte("<");
                    default: send_byte(">");
                endcase
                if ($urandom_range(1)) send_byte("=");
            end else if (r < 83) begin
                send_byte(rand_punct());
            end else if (r < 86) begin
                send_byte(rand_bad());
                repeat ($urandom_range(4)) send_byte(8'($urandom_range(1, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(rand_space());
            end
            if ($urandom_range(4) < 2) send_byte(rand_space());
        end
        send_byte(TEXT_END);
    endtask

    // ------------------------------------------------------------------------
    // Token receiver: ready changes on the falling edge. On request it holds
    // ready low, counted down in hold_left, so the queue fills and the
    // block pushes back on the byte side.
    // ------------------------------------------------------------------------
    initial begin : token_sink
        int hold_left;
        hold_left    = 0;
        tok_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                tok_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                tok_ch.ready <= 1'b0;
            end else begin
                tok_ch.ready <= snk_calm || ($urandom_range(99) >= 7);
            end
        end
    end

    // token monitor, sampled on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1)
            tokens.check_token(t_tok'({tok_ch.kind, tok_ch.start_pos, tok_ch.tok_len,
                                       tok_ch.num_value, tok_ch.last}));
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int base;
        int next_hold;
        int waited;
        byte_ch.valid = 1'b0;
        byte_ch.ch    = 8'h00;
        bytes_sent    = 0;
        texts_sent    = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts. First: keyword closed by a pairable, ">=", a number
        // closed by a pending '!', '!' closed by an identifier, DEL ending the
        // identifier (flush plus error), ignored bytes, then the end byte.
        send_text("if>=12!_");
        send_byte(8'h7F);
        send_text(" q");
        send_byte(TEXT_END);
        // keyword plus punctuator from one byte, "return", a 0xFF error
        send_text("else;return");
        send_byte(8'hFF);
        send_byte(TEXT_END);
        // pending operator flushed by the end byte
        send_text("=");
        send_byte(TEXT_END);

        // Random texts, with a calm stretch in the middle and a long output
        // stall every few hundred bytes.
        base      = bytes_sent;
        next_hold = 200;
        while (bytes_sent - base < 1900) begin
            src_calm = (bytes_sent - base >= 800) && (bytes_sent - base < 1100);
            snk_calm = src_calm;
            if (bytes_sent - base >= next_hold) begin
                hold_req  = 1'b1;
                next_hold += 450;
            end
            send_random_text();
        end
        src_calm = 1'b0;
        snk_calm = 1'b0;
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;

        // drain, then keep watching for anything stray
        waited = 0;
        while (tokens.outstanding() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (tokens.outstanding() != 0) begin
            $display("%0t ns: %0d tokens expected but never seen", $time,
                     tokens.outstanding());
            tokens.failures++;
        end

        $display("Sent %0d bytes in %0d texts under idling and stalls; checked %0d tokens.",
                 bytes_sent, texts_sent, tokens.checked);
        $display("num %0d (%0d saturated), ident %0d, kw %0d, punct %0d, end %0d, err %0d.",
                 tokens.seen[K_NUM], tokens.saturated, tokens.seen[K_IDENT],
                 tokens.seen[K_KEYWORD], tokens.seen[K_PUNCT], tokens.seen[K_END],
                 tokens.seen[K_ERROR]);
        if (tokens.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/clx_pkg.sv
rtl/core/clx_byte_if.sv
rtl/core/clx_tok_if.sv
rtl/core/clx_step.sv
rtl/core/clx_out_fifo.sv
rtl/core/c_subset_lexer_unit.sv
bench/c_subset_lexer_unit_test.sv
